FILE: rtl/core/jtag_pkg.sv
// Shared types and constants for the JTAG TAP master sequencer.
// Holds the TAP state encoding, the TAP transition function and the sequencer states.
// Used by jtag_tap_master_sequencer_core and jtag_chk; depends on nothing.
package jtag_pkg;

  // Default for the largest number of data bits in one shift.
  localparam int MaxBitsDef = 32;

  // TMS-high clocks that force the TAP into Test-Logic-Reset.
  localparam int ResetClocks = 5;

  // Command codes.
  localparam logic [1:0] OP_RESET   = 2'd0;
  localparam logic [1:0] OP_CAP_DR  = 2'd1;
  localparam logic [1:0] OP_CAP_IR  = 2'd2;
  localparam logic [1:0] OP_SHIFT   = 2'd3;

  // Exit modes of a shift.
  localparam logic [1:0] EXIT_STAY   = 2'd0;
  localparam logic [1:0] EXIT_EXIT1  = 2'd1;
  localparam logic [1:0] EXIT_IDLE   = 2'd2;
  localparam logic [1:0] EXIT_UPDATE = 2'd3;

  // TAP controller states in the standard encoding.
  typedef enum logic [3:0] {
    TAP_EX2DR   = 4'h0,
    TAP_EX1DR   = 4'h1,
    TAP_SHDR    = 4'h2,
    TAP_PAUSEDR = 4'h3,
    TAP_SELIR   = 4'h4,
    TAP_UPDDR   = 4'h5,
    TAP_CAPDR   = 4'h6,
    TAP_SELDR   = 4'h7,
    TAP_EX2IR   = 4'h8,
    TAP_EX1IR   = 4'h9,
    TAP_SHIR    = 4'hA,
    TAP_PAUSEIR = 4'hB,
    TAP_RTI     = 4'hC,
    TAP_UPDIR   = 4'hD,
    TAP_CAPIR   = 4'hE,
    TAP_TLR     = 4'hF
  } tap_t;

  // Sequencer states; every state but SEQ_IDLE emits TCK-cycle words.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RST_HI,
    SEQ_RST_LO,
    SEQ_CAP_HI1,
    SEQ_CAP_HI2,
    SEQ_CAP_LO,
    SEQ_SH_PAD,
    SEQ_SH_BIT,
    SEQ_TAIL_HI,
    SEQ_TAIL_LO
  } seq_t;

  // TAP controller transition on a TCK edge.
  function automatic tap_t tap_next(input tap_t cur, input logic tms_bit);
    tap_t nxt;
    nxt = TAP_TLR;
    unique case (cur)
      TAP_EX2DR:   nxt = tms_bit ? TAP_UPDDR : TAP_SHDR;
      TAP_EX1DR:   nxt = tms_bit ? TAP_UPDDR : TAP_PAUSEDR;
      TAP_SHDR:    nxt = tms_bit ? TAP_EX1DR : TAP_SHDR;
      TAP_PAUSEDR: nxt = tms_bit ? TAP_EX2DR : TAP_PAUSEDR;
      TAP_SELIR:   nxt = tms_bit ? TAP_TLR   : TAP_CAPIR;
      TAP_UPDDR:   nxt = tms_bit ? TAP_SELDR : TAP_RTI;
      TAP_CAPDR:   nxt = tms_bit ? TAP_EX1DR : TAP_SHDR;
      TAP_SELDR:   nxt = tms_bit ? TAP_SELIR : TAP_CAPDR;
      TAP_EX2IR:   nxt = tms_bit ? TAP_UPDIR : TAP_SHIR;
      TAP_EX1IR:   nxt = tms_bit ? TAP_UPDIR : TAP_PAUSEIR;
      TAP_SHIR:    nxt = tms_bit ? TAP_EX1IR : TAP_SHIR;
      TAP_PAUSEIR: nxt = tms_bit ? TAP_EX2IR : TAP_PAUSEIR;
      TAP_RTI:     nxt = tms_bit ? TAP_SELDR : TAP_RTI;
      TAP_UPDIR:   nxt = tms_bit ? TAP_SELDR : TAP_RTI;
      TAP_CAPIR:   nxt = tms_bit ? TAP_EX1IR : TAP_SHIR;
      TAP_TLR:     nxt = tms_bit ? TAP_TLR   : TAP_RTI;
      default:     nxt = TAP_TLR;
    endcase
    return nxt;
  endfunction

endpackage

FILE: rtl/core/jtag_tap_master_sequencer_core.sv
// JTAG TAP master sequencer: turns one command word into a stream of TCK-cycle words.
// A small state machine with one shared bit counter drives TMS/TDI and tracks the TAP.
// Depends on jtag_pkg.
//
// Usage: the input channel (in_valid/in_ready) takes one command word: reset,
// capture DR, capture IR or shift, with shift length, TDI data, capture length and
// exit mode. The output channel (out_valid/out_ready) gives one word per TCK cycle:
// tms, tdi, capture_tdo, bit_index, bad_state and last on the final word.
// The command and the sequencer state are registered on acceptance; the output
// register then takes the first word once it is free. Throughput: one word per cycle
// while out_ready is high within a command. A reset command emits 6 words, capture DR 2,
// capture IR 3 and shift up to MAX_BITS + 3; the sequencer passes through idle to
// accept each command. The output handshake sets this pace, and in_ready is high
// only while the sequencer has no command. The next command is taken while the
// final word of the previous one still waits. A shift of zero bits that needs no pad
// and no tail clocks emits nothing. When a valid word meets a low out_ready, the
// output register holds it and the sequencer waits. Reset empties the output register,
// idles the sequencer and sets the tracked TAP state to Test-Logic-Reset.
module jtag_tap_master_sequencer_core #(
  parameter int MAX_BITS = jtag_pkg::MaxBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [5:0]  shift_len,
  input  logic [31:0] shift_data,
  input  logic [5:0]  capture_len,
  input  logic [1:0]  exit_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tms,
  output logic        tdi,
  output logic        capture_tdo,
  output logic [4:0]  bit_index,
  output logic        bad_state,
  output logic        last
);

  // Counter holds a data bit index, a reset clock count or the capture IR flag.
  localparam int LenW  = $clog2(MAX_BITS + 1);
  localparam int CntW  = (LenW > 3) ? LenW : 3;

  jtag_pkg::seq_t   state, state_next;
  jtag_pkg::tap_t   tap_pos, tap_pos_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [CntW-1:0]  len;
  logic [31:0]      data_sr;
  logic [5:0]       caplen;
  logic [1:0]       exitm;
  logic             bad;

  logic             accept;
  logic             emit;
  logic [CntW-1:0]  len_sat;
  logic             start_bad;
  logic             in_capture;
  jtag_pkg::seq_t   after_data;
  jtag_pkg::seq_t   sat_after_data;

  logic             r_tms;
  logic             r_tdi;
  logic             r_cap;
  logic [4:0]       r_idx;

  assign in_ready = (state == jtag_pkg::SEQ_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state != jtag_pkg::SEQ_IDLE) && (!out_valid || out_ready);

  // Saturate the shift length and classify the starting TAP state.
  always_comb begin
    if (int'(shift_len) > MAX_BITS) begin
      len_sat = CntW'(MAX_BITS);
    end else begin
      len_sat = CntW'(shift_len);
    end
    in_capture = (tap_pos == jtag_pkg::TAP_CAPDR) || (tap_pos == jtag_pkg::TAP_CAPIR);
    start_bad  = 1'b0;
    unique case (operation)
      jtag_pkg::OP_RESET: start_bad = 1'b0;
      jtag_pkg::OP_CAP_DR, jtag_pkg::OP_CAP_IR:
        start_bad = !((tap_pos == jtag_pkg::TAP_RTI) ||
                      (tap_pos == jtag_pkg::TAP_UPDDR) ||
                      (tap_pos == jtag_pkg::TAP_UPDIR));
      jtag_pkg::OP_SHIFT:
        start_bad = !(in_capture ||
                      (tap_pos == jtag_pkg::TAP_SHDR) || (tap_pos == jtag_pkg::TAP_EX2DR) ||
                      (tap_pos == jtag_pkg::TAP_SHIR) || (tap_pos == jtag_pkg::TAP_EX2IR));
      default: start_bad = 1'b0;
    endcase
  end

  // Where a shift goes once its data bits are done, for the stored and incoming modes.
  always_comb begin
    if ((exitm == jtag_pkg::EXIT_IDLE) || (exitm == jtag_pkg::EXIT_UPDATE)) begin
      after_data = jtag_pkg::SEQ_TAIL_HI;
    end else begin
      after_data = jtag_pkg::SEQ_IDLE;
    end
    if ((exit_mode == jtag_pkg::EXIT_IDLE) || (exit_mode == jtag_pkg::EXIT_UPDATE)) begin
      sat_after_data = jtag_pkg::SEQ_TAIL_HI;
    end else begin
      sat_after_data = jtag_pkg::SEQ_IDLE;
    end
  end

  // Next state of the sequencer and its counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      jtag_pkg::SEQ_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          unique case (operation)
            jtag_pkg::OP_RESET:  state_next = jtag_pkg::SEQ_RST_HI;
            jtag_pkg::OP_CAP_DR: state_next = jtag_pkg::SEQ_CAP_HI1;
            jtag_pkg::OP_CAP_IR: state_next = jtag_pkg::SEQ_CAP_HI1;
            jtag_pkg::OP_SHIFT: begin
              if (in_capture) begin
                state_next = jtag_pkg::SEQ_SH_PAD;
              end else if (len_sat != '0) begin
                state_next = jtag_pkg::SEQ_SH_BIT;
              end else begin
                state_next = sat_after_data;
              end
            end
            default: state_next = jtag_pkg::SEQ_IDLE;
          endcase
        end
      end
      jtag_pkg::SEQ_RST_HI: begin
        if (emit) begin
          if (cnt == CntW'(jtag_pkg::ResetClocks - 1)) begin
            state_next = jtag_pkg::SEQ_RST_LO;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + CntW'(1);
          end
        end
      end
      jtag_pkg::SEQ_RST_LO: begin
        if (emit) state_next = jtag_pkg::SEQ_IDLE;
      end
      jtag_pkg::SEQ_CAP_HI1: begin
        if (emit) state_next = (cnt[0]) ? jtag_pkg::SEQ_CAP_HI2 : jtag_pkg::SEQ_CAP_LO;
      end
      jtag_pkg::SEQ_CAP_HI2: begin
        if (emit) state_next = jtag_pkg::SEQ_CAP_LO;
      end
      jtag_pkg::SEQ_CAP_LO: begin
        if (emit) begin
          state_next = jtag_pkg::SEQ_IDLE;
          cnt_next   = '0;
        end
      end
      jtag_pkg::SEQ_SH_PAD: begin
        if (emit) state_next = (len != '0) ? jtag_pkg::SEQ_SH_BIT : after_data;
      end
      jtag_pkg::SEQ_SH_BIT: begin
        if (emit) begin
          if (cnt == len - CntW'(1)) begin
            state_next = after_data;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + CntW'(1);
          end
        end
      end
      jtag_pkg::SEQ_TAIL_HI: begin
        if (emit) begin
          state_next = (exitm == jtag_pkg::EXIT_IDLE) ? jtag_pkg::SEQ_TAIL_LO
                                                       : jtag_pkg::SEQ_IDLE;
        end
      end
      jtag_pkg::SEQ_TAIL_LO: begin
        if (emit) state_next = jtag_pkg::SEQ_IDLE;
      end
      default: state_next = jtag_pkg::SEQ_IDLE;
    endcase
    // Capture IR uses the counter's low bit to ask for a second TMS-high clock.
    if ((state == jtag_pkg::SEQ_IDLE) && accept && (operation == jtag_pkg::OP_CAP_IR)) begin
      cnt_next = CntW'(1);
    end
  end

  // Word for the current TCK cycle, decoded from the sequencer state.
  always_comb begin
    r_tms = 1'b0;
    r_tdi = 1'b0;
    r_cap = 1'b0;
    r_idx = '0;
    unique case (state)
      jtag_pkg::SEQ_RST_HI, jtag_pkg::SEQ_CAP_HI1, jtag_pkg::SEQ_CAP_HI2,
      jtag_pkg::SEQ_TAIL_HI: begin
        r_tms = 1'b1;
      end
      jtag_pkg::SEQ_SH_BIT: begin
        r_tms = (exitm != jtag_pkg::EXIT_STAY) && (cnt == len - CntW'(1));
        r_tdi = data_sr[0];
        r_cap = (6'(cnt) < caplen);
        r_idx = r_cap ? 5'(cnt) : 5'd0;
      end
      default: begin
        r_tms = 1'b0;
      end
    endcase
  end

  assign tap_pos_next = emit ? jtag_pkg::tap_next(tap_pos, r_tms) : tap_pos;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jtag_pkg::SEQ_IDLE;
      cnt       <= '0;
      tap_pos   <= jtag_pkg::TAP_TLR;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      tap_pos <= tap_pos_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command registers; the data shifts right one bit per data clock.
  always_ff @(posedge clk) begin
    if (accept) begin
      len     <= len_sat;
      data_sr <= shift_data;
      caplen  <= capture_len;
      exitm   <= exit_mode;
      bad     <= start_bad;
    end else if (emit && (state == jtag_pkg::SEQ_SH_BIT)) begin
      data_sr <= {1'b0, data_sr[31:1]};
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      tms         <= r_tms;
      tdi         <= r_tdi;
      capture_tdo <= r_cap;
      bit_index   <= r_idx;
      bad_state   <= bad;
      last        <= (state_next == jtag_pkg::SEQ_IDLE);
    end
  end

endmodule

FILE: rtl/core/jtag_chk.sv
// Port-level checker for jtag_tap_master_sequencer_core, with its bind statement.
// Depends on jtag_pkg for the command codes.
module jtag_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tms,
  input logic        tdi,
  input logic        capture_tdo,
  input logic [4:0]  bit_index,
  input logic        bad_state,
  input logic        last
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tms) && $stable(tdi) &&
      $stable(capture_tdo) && $stable(bit_index) && $stable(bad_state) && $stable(last))
    else $error("output word changed while stalled");

  // Reset and capture commands always emit words, so the block goes busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation != jtag_pkg::OP_SHIFT) |=> !in_ready)
    else $error("block ready right after a command that must emit words");

  // A word left waiting while the block is ready must close its command.
  a_last_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last)
    else $error("pending word is not the last of its command");

  // A bit index only appears with a kept TDO bit.
  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !capture_tdo |-> (bit_index == 5'd0))
    else $error("bit index set without a TDO capture");

endmodule

bind jtag_tap_master_sequencer_core jtag_chk u_jtag_chk (.*);

FILE: bench/tb_jtag_tap_master_sequencer_core.sv
// Self-checking testbench for jtag_tap_master_sequencer_core: drives command words and
// predicts every TCK-cycle word, tracking the TAP state from the predicted TMS values.
// Depends on jtag_pkg and jtag_tap_master_sequencer_core.
`timescale 1ns / 100ps

module tb_jtag_tap_master_sequencer_core;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_AT        = 120;
  localparam int DRAIN_AT       = 260;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Next TAP state per current state, one nibble per state, for TMS low and TMS high.
  localparam logic [63:0] NEXT_ON_TMS_LOW  = 64'hCACC_BABA_62CE_3232;
  localparam logic [63:0] NEXT_ON_TMS_HIGH = 64'hF977_89DD_417F_0155;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  len;
    logic [31:0] data;
    logic [5:0]  cap_len;
    logic [1:0]  exit_sel;
  } jtag_cmd_t;

  typedef struct packed {
    logic       tms;
    logic       tdi;
    logic       cap;
    logic [4:0] idx;
    logic       bad;
    logic       last;
  } tck_word_t;

  // Predicts the TCK words of each accepted command and checks them in order.
  class tck_ledger;
    tck_word_t        expected_q[$];
    tck_word_t        burst_q[$];
    jtag_pkg::tap_t   tap_now;
    int               failures;

    function new();
      tap_now  = jtag_pkg::TAP_TLR;
      failures = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    endfunction

    // One TCK cycle: record the word and move the tracked TAP state.
    function void clock_out(logic tms_v, logic tdi_v, logic cap_v, logic [4:0] idx_v);
      tck_word_t w;
      w.tms  = tms_v;
      w.tdi  = tdi_v;
      w.cap  = cap_v;
      w.idx  = cap_v ? idx_v : 5'd0;
      w.bad  = 1'b0;
      w.last = 1'b0;
      burst_q.push_back(w);
      if (tms_v) tap_now = jtag_pkg::tap_t'(NEXT_ON_TMS_HIGH[tap_now*4 +: 4]);
      else tap_now = jtag_pkg::tap_t'(NEXT_ON_TMS_LOW[tap_now*4 +: 4]);
    endfunction

    function void note_command(jtag_cmd_t c);
      jtag_pkg::tap_t start;
      logic flagged;
      int   n_bits;
      start   = tap_now;
      flagged = 1'b0;
      burst_q.delete();
      case (c.op)
        jtag_pkg::OP_RESET: begin
          for (int k = 0; k < jtag_pkg::ResetClocks; k++)
            clock_out(1'b1, 1'b0, 1'b0, 5'd0);
          clock_out(1'b0, 1'b0, 1'b0, 5'd0);
        end
        jtag_pkg::OP_CAP_DR, jtag_pkg::OP_CAP_IR: begin
          flagged = !(start inside {jtag_pkg::TAP_RTI, jtag_pkg::TAP_UPDDR,
                                    jtag_pkg::TAP_UPDIR});
          clock_out(1'b1, 1'b0, 1'b0, 5'd0);
          if (c.op == jtag_pkg::OP_CAP_IR) clock_out(1'b1, 1'b0, 1'b0, 5'd0);
          clock_out(1'b0, 1'b0, 1'b0, 5'd0);
        end
        default: begin
          flagged = !(start inside {jtag_pkg::TAP_CAPDR, jtag_pkg::TAP_SHDR,
                                    jtag_pkg::TAP_EX2DR, jtag_pkg::TAP_CAPIR,
                                    jtag_pkg::TAP_SHIR, jtag_pkg::TAP_EX2IR});
          n_bits = (c.len > jtag_pkg::MaxBitsDef) ? jtag_pkg::MaxBitsDef : int'(c.len);
          // A Capture state needs a pad clock with TMS low to get into Shift.
          if (start == jtag_pkg::TAP_CAPDR || start == jtag_pkg::TAP_CAPIR)
            clock_out(1'b0, 1'b0, 1'b0, 5'd0);
          for (int i = 0; i < n_bits; i++) begin
            clock_out(c.exit_sel != jtag_pkg::EXIT_STAY && i == n_bits - 1,
                      (i < 32) ? c.data[i] : 1'b0, i < c.cap_len, 5'(i));
          end
          if (c.exit_sel == jtag_pkg::EXIT_IDLE) begin
            clock_out(1'b1, 1'b0, 1'b0, 5'd0);
            clock_out(1'b0, 1'b0, 1'b0, 5'd0);
          end else if (c.exit_sel == jtag_pkg::EXIT_UPDATE) begin
            clock_out(1'b1, 1'b0, 1'b0, 5'd0);
          end
        end
      endcase
      foreach (burst_q[k]) begin
        burst_q[k].bad  = flagged;
        burst_q[k].last = (k == burst_q.size() - 1);
        expected_q.push_back(burst_q[k]);
      end
    endfunction

    function void check_word(tck_word_t got);
      tck_word_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected word tms=%0b tdi=%0b cap=%0b idx=%0d bad=%0b last=%0b",
                       got.tms, got.tdi, got.cap, got.idx, got.bad, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.tms !== want.tms || got.tdi !== want.tdi || got.cap !== want.cap ||
          got.idx !== want.idx || got.bad !== want.bad || got.last !== want.last) begin
        flag($sformatf({"word mismatch: expected tms=%0b tdi=%0b cap=%0b idx=%0d bad=%0b ",
                        "last=%0b, got tms=%0b tdi=%0b cap=%0b idx=%0d bad=%0b last=%0b"},
                       want.tms, want.tdi, want.cap, want.idx, want.bad, want.last,
                       got.tms, got.tdi, got.cap, got.idx, got.bad, got.last));
      end
    endfunction

    function void close_out();
      if (expected_q.size() != 0)
        flag($sformatf("%0d expected words never arrived", expected_q.size()));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [5:0]  shift_len;
  logic [31:0] shift_data;
  logic [5:0]  capture_len;
  logic [1:0]  exit_mode;
  logic        out_valid;
  logic        out_ready;
  logic        tms;
  logic        tdi;
  logic        capture_tdo;
  logic [4:0]  bit_index;
  logic        bad_state;
  logic        last;

  tck_ledger ledger = new();
  int        sent_count = 0;
  int        rush_left = 0;
  int        stall_cycles = 0;

  jtag_tap_master_sequencer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .shift_len   (shift_len),
    .shift_data  (shift_data),
    .capture_len (capture_len),
    .exit_mode   (exit_mode),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tms         (tms),
    .tdi         (tdi),
    .capture_tdo (capture_tdo),
    .bit_index   (bit_index),
    .bad_state   (bad_state),
    .last        (last)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Output side: check every accepted word and watch for a hung handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        ledger.check_word('{tms, tdi, capture_tdo, bit_index, bad_state, last});
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, ready stretches, and one long hold once enough words went in.
  initial begin
    int r;
    int n;
    logic v;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          v = 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 90) begin
          v = 1'b0;
          n = $urandom_range(1, 3);
        end else if (r < 97) begin
          v = 1'b0;
          n = $urandom_range(10, 40);
        end else begin
          v = 1'b1;
          n = $urandom_range(40, 100);
        end
        out_ready <= v;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Sender gap between words: mostly none or short, a few long, some runs with none.
  function automatic int pick_gap();
    int r;
    if (rush_left > 0) begin
      rush_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      rush_left = $urandom_range(15, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command word, wait for acceptance, then idle or pause as planned.
  task automatic send_command(input jtag_cmd_t c);
    int gap;
    operation   <= c.op;
    shift_len   <= c.len;
    shift_data  <= c.data;
    capture_len <= c.cap_len;
    exit_mode   <= c.exit_sel;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_command(c);
    sent_count++;
    if (sent_count == HOLD_AT) begin
      rush_left = 16;
    end
    if (sent_count == DRAIN_AT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (ledger.pending() != 0) @(posedge clk);
    end else begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic issue(input logic [1:0] op, input logic [5:0] len, input logic [31:0] data,
                       input logic [5:0] cap_len, input logic [1:0] exit_sel);
    jtag_cmd_t c;
    c = '{op, len, data, cap_len, exit_sel};
    send_command(c);
  endtask

  // Shift length: mostly in range, with zero, the maximum and oversize lengths mixed in.
  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 6'd0;
    if (r < 14) return 6'($urandom_range(33, 63));
    if (r < 24) return 6'd32;
    return 6'($urandom_range(1, 31));
  endfunction

  function automatic logic [5:0] pick_cap(input logic [5:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 6'($urandom_range(0, len));
    if (r < 55) return 6'd0;
    return 6'($urandom_range(0, 63));
  endfunction

  // An optional reset, a capture, then one to three shifts with random content.
  task automatic issue_scan();
    int n_shift;
    logic [5:0] len;
    logic [1:0] exit_sel;
    if ($urandom_range(0, 9) == 0)
      issue(jtag_pkg::OP_RESET, 6'($urandom), $urandom, 6'($urandom), 2'($urandom));
    issue($urandom_range(0, 1) ? jtag_pkg::OP_CAP_DR : jtag_pkg::OP_CAP_IR,
          6'($urandom), $urandom, 6'($urandom), 2'($urandom));
    n_shift = $urandom_range(1, 3);
    for (int k = 0; k < n_shift; k++) begin
      len = pick_len();
      if (k < n_shift - 1) exit_sel = jtag_pkg::EXIT_STAY;
      else if ($urandom_range(0, 9) < 7)
        exit_sel = $urandom_range(0, 1) ? jtag_pkg::EXIT_IDLE : jtag_pkg::EXIT_UPDATE;
      else exit_sel = 2'($urandom);
      issue(jtag_pkg::OP_SHIFT, len, $urandom, pick_cap(len), exit_sel);
    end
  endtask

  // Main sequence: reset, directed commands, random scans and noise, then drain.
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= jtag_pkg::OP_RESET;
    shift_len   <= 6'd0;
    shift_data  <= 32'd0;
    capture_len <= 6'd0;
    exit_mode   <= jtag_pkg::EXIT_STAY;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, field extremes, states the sequencer does not expect.
    issue(jtag_pkg::OP_RESET, 6'd63, 32'hFFFF_FFFF, 6'd63, jtag_pkg::EXIT_UPDATE);
    issue(jtag_pkg::OP_CAP_DR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd32, 32'hFFFF_FFFF, 6'd32, jtag_pkg::EXIT_IDLE);
    issue(jtag_pkg::OP_CAP_IR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd1, 32'd0, 6'd0, jtag_pkg::EXIT_UPDATE);
    issue(jtag_pkg::OP_CAP_DR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    // Zero-length shift from Capture emits only the pad clock; from Shift it emits nothing.
    issue(jtag_pkg::OP_SHIFT, 6'd0, 32'hFFFF_FFFF, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd0, 32'hFFFF_FFFF, 6'd63, jtag_pkg::EXIT_STAY);
    // Oversize length saturates; capture length beyond it keeps every bit.
    issue(jtag_pkg::OP_SHIFT, 6'd63, 32'hA5A5_5A5A, 6'd63, jtag_pkg::EXIT_EXIT1);
    // Walk from Exit1 through Pause to Exit2, then a legal shift out of Exit2.
    issue(jtag_pkg::OP_SHIFT, 6'd1, 32'd1, 6'd1, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd1, 32'd0, 6'd1, jtag_pkg::EXIT_EXIT1);
    issue(jtag_pkg::OP_SHIFT, 6'd5, 32'h0000_0015, 6'd3, jtag_pkg::EXIT_IDLE);
    issue(jtag_pkg::OP_SHIFT, 6'd40, 32'h8000_0001, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_CAP_IR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_IDLE);
    issue(jtag_pkg::OP_CAP_DR, 6'd17, 32'h1234_5678, 6'd9, jtag_pkg::EXIT_IDLE);
    issue(jtag_pkg::OP_SHIFT, 6'd16, 32'h5555_AAAA, 6'd8, jtag_pkg::EXIT_EXIT1);
    issue(jtag_pkg::OP_CAP_IR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_RESET, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_SHIFT, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_UPDATE);
    issue(jtag_pkg::OP_SHIFT, 6'd3, 32'h0000_0007, 6'd2, jtag_pkg::EXIT_IDLE);
    issue(jtag_pkg::OP_CAP_DR, 6'd0, 32'd0, 6'd0, jtag_pkg::EXIT_STAY);
    issue(jtag_pkg::OP_RESET, 6'd32, 32'h0F0F_F0F0, 6'd32, jtag_pkg::EXIT_IDLE);

    // Random: mostly well-formed scans, the rest unconstrained commands.
    while (sent_count < 23 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 75) issue_scan();
      else issue(2'($urandom), 6'($urandom), $urandom, 6'($urandom), 2'($urandom));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    ledger.close_out();
    if (ledger.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
